// ===== sv/usb_standard_request_handler_macros.svh =====
// Assertion macros shared by the standard request handler RTL.
`ifndef USB_STANDARD_REQUEST_HANDLER_MACROS_SVH
`define USB_STANDARD_REQUEST_HANDLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define USBREQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("usbreq same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define USBREQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("usbreq next-cycle check failed");

`endif

// ===== sv/usbreq_pkg.sv =====
// Types and constants of the USB standard request handler.
`default_nettype none

package usbreq_pkg;

	// Command codes of a decoded setup request
	typedef enum logic [3:0] {
		CMD_GET_STATUS     = 4'd0,
		CMD_CLEAR_FEATURE  = 4'd1,
		CMD_SET_FEATURE    = 4'd2,
		CMD_SET_ADDRESS    = 4'd3,
		CMD_GET_DESCRIPTOR = 4'd4,
		CMD_GET_CONFIG     = 4'd5,
		CMD_SET_CONFIG     = 4'd6,
		CMD_GET_INTERFACE  = 4'd7,
		CMD_SET_INTERFACE  = 4'd8,
		CMD_SET_IDLE       = 4'd9,
		CMD_SET_REPORT     = 4'd10,
		CMD_OTHER          = 4'd11
	} cmd_t;

	// Configuration register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_DEVICE_DESC_LEN    = 3'd0,
		REG_CONFIG_TOTAL_LEN   = 3'd1,
		REG_INTERFACE_DESC_LEN = 3'd2,
		REG_ENDPOINT_DESC_LEN  = 3'd3,
		REG_HID_DESC_LEN       = 3'd4,
		REG_REPORT_DESC_LEN    = 3'd5,
		REG_STRING_LENS        = 3'd6
	} reg_idx_t;

	// Device state codes
	typedef logic [1:0] dev_state_t;
	localparam dev_state_t ST_DEFAULT    = 2'd0;
	localparam dev_state_t ST_ADDRESSED  = 2'd1;
	localparam dev_state_t ST_CONFIGURED = 2'd2;

	// Data phase codes
	typedef logic [1:0] phase_t;
	localparam phase_t PH_STATUS = 2'd0;
	localparam phase_t PH_TX     = 2'd1;
	localparam phase_t PH_RX     = 2'd2;

	// Reply source codes
	typedef logic [2:0] src_t;
	localparam src_t SRC_INLINE    = 3'd0;
	localparam src_t SRC_DEVICE    = 3'd1;
	localparam src_t SRC_CONFIG    = 3'd2;
	localparam src_t SRC_STRING    = 3'd3;
	localparam src_t SRC_INTERFACE = 3'd4;
	localparam src_t SRC_ENDPOINT  = 3'd5;
	localparam src_t SRC_HID       = 3'd6;
	localparam src_t SRC_REPORT    = 3'd7;

	// bmRequestType values
	localparam logic [7:0] RT_H2D_DEVICE    = 8'h00;
	localparam logic [7:0] RT_H2D_INTERFACE = 8'h01;
	localparam logic [7:0] RT_H2D_ENDPOINT  = 8'h02;
	localparam logic [7:0] RT_D2H_DEVICE    = 8'h80;
	localparam logic [7:0] RT_D2H_INTERFACE = 8'h81;
	localparam logic [7:0] RT_D2H_ENDPOINT  = 8'h82;

	// Descriptor types in the high byte of wValue
	localparam logic [7:0] DT_DEVICE    = 8'h01;
	localparam logic [7:0] DT_CONFIG    = 8'h02;
	localparam logic [7:0] DT_STRING    = 8'h03;
	localparam logic [7:0] DT_INTERFACE = 8'h04;
	localparam logic [7:0] DT_ENDPOINT  = 8'h05;
	localparam logic [7:0] DT_HID       = 8'h21;
	localparam logic [7:0] DT_REPORT    = 8'h22;

	localparam logic [7:0]  EP1_IN_ADDR  = 8'h81;
	localparam logic [7:0]  FEAT_EP_HALT = 8'h00;
	localparam logic [15:0] MAX_ADDRESS  = 16'h007f;
	localparam logic [15:0] WORD_ZERO    = 16'h0000;
	localparam int          NUM_STRINGS  = 3;

	// Input beat, last member in the lowest bits
	typedef struct packed {
		logic [15:0] setup_length;
		logic [15:0] setup_index;
		logic [15:0] setup_value;
		logic [7:0]  request_type;
		logic [3:0]  cmd;
	} req_t;

	// Result beat, last member in the lowest bits
	typedef struct packed {
		logic        ep1_halted_out;
		dev_state_t  device_state_out;
		logic [6:0]  new_address;
		logic        address_pending;
		logic [15:0] data_len;
		logic        inline_byte;
		logic [1:0]  string_number;
		src_t        reply_source;
		phase_t      phase;
		logic        stall_res;
	} res_t;

	// Device state kept across requests
	typedef struct packed {
		dev_state_t state;
		logic       ep1_halted;
	} dev_t;

	// Descriptor length registers
	typedef struct packed {
		logic [7:0]  device_desc_len;
		logic [15:0] config_total_len;
		logic [7:0]  interface_desc_len;
		logic [7:0]  endpoint_desc_len;
		logic [7:0]  hid_desc_len;
		logic [15:0] report_desc_len;
		logic [23:0] string_lens;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/usbreq_decode.sv =====
// Request checker: one setup request plus device state in, result and next state out.
`default_nettype none

module usbreq_decode (
	input  usbreq_pkg::req_t req,
	input  usbreq_pkg::cfg_t cfg,
	input  usbreq_pkg::dev_t cur,
	output usbreq_pkg::res_t res,
	output usbreq_pkg::dev_t nxt
);

	logic                   stall;
	usbreq_pkg::phase_t     phase;
	usbreq_pkg::src_t       src;
	logic [1:0]             strn;
	logic                   ibyte;
	logic [15:0]            dlen;
	logic                   apend;
	logic [6:0]             naddr;
	logic                   trunc;
	logic                   configured;
	logic [23:0]            str_sh;
	logic [7:0]             vlo;
	logic [7:0]             vhi;
	logic [7:0]             ilo;
	logic [7:0]             ihi;
	logic [7:0]             rt;
	logic [15:0]            val;
	logic [15:0]            idx;
	logic [15:0]            len;
	usbreq_pkg::dev_t       upd;

	assign rt  = req.request_type;
	assign val = req.setup_value;
	assign idx = req.setup_index;
	assign len = req.setup_length;
	assign vlo = val[7:0];
	assign vhi = val[15:8];
	assign ilo = idx[7:0];
	assign ihi = idx[15:8];
	assign configured = (cur.state == usbreq_pkg::ST_CONFIGURED);
	assign str_sh = cfg.string_lens >> {vlo[1:0], 3'b000};

	// Per-command checks
	always_comb begin
		stall = 1'b0;
		phase = usbreq_pkg::PH_STATUS;
		src   = usbreq_pkg::SRC_INLINE;
		strn  = 2'd0;
		ibyte = 1'b0;
		dlen  = 16'd0;
		apend = 1'b0;
		naddr = 7'd0;
		trunc = 1'b1;
		upd   = cur;
		case (req.cmd)
			usbreq_pkg::CMD_GET_STATUS: begin
				if (val != usbreq_pkg::WORD_ZERO || len != 16'd2) begin
					stall = 1'b1;
				end else if (rt == usbreq_pkg::RT_D2H_DEVICE) begin
					stall = (idx != usbreq_pkg::WORD_ZERO);
				end else if (rt == usbreq_pkg::RT_D2H_INTERFACE) begin
					stall = !configured || idx != usbreq_pkg::WORD_ZERO;
				end else if (rt == usbreq_pkg::RT_D2H_ENDPOINT) begin
					if (!configured || ihi != 8'd0 || ilo != usbreq_pkg::EP1_IN_ADDR)
						stall = 1'b1;
					else
						ibyte = cur.ep1_halted;
				end else begin
					stall = 1'b1;
				end
				phase = usbreq_pkg::PH_TX;
				dlen  = 16'd2;
			end
			usbreq_pkg::CMD_CLEAR_FEATURE, usbreq_pkg::CMD_SET_FEATURE: begin
				if (!configured || val != usbreq_pkg::WORD_ZERO || len != usbreq_pkg::WORD_ZERO
						|| rt != usbreq_pkg::RT_H2D_ENDPOINT || vlo != usbreq_pkg::FEAT_EP_HALT
						|| ilo != usbreq_pkg::EP1_IN_ADDR)
					stall = 1'b1;
				else
					upd.ep1_halted = (req.cmd == usbreq_pkg::CMD_SET_FEATURE);
			end
			usbreq_pkg::CMD_SET_ADDRESS: begin
				if (rt != usbreq_pkg::RT_H2D_DEVICE || idx != usbreq_pkg::WORD_ZERO
						|| len != usbreq_pkg::WORD_ZERO || val == usbreq_pkg::WORD_ZERO
						|| val > usbreq_pkg::MAX_ADDRESS) begin
					stall = 1'b1;
				end else begin
					apend     = 1'b1;
					naddr     = val[6:0];
					upd.state = usbreq_pkg::ST_ADDRESSED;
				end
			end
			usbreq_pkg::CMD_GET_DESCRIPTOR: begin
				phase = usbreq_pkg::PH_TX;
				case (vhi)
					usbreq_pkg::DT_DEVICE: begin
						src  = usbreq_pkg::SRC_DEVICE;
						dlen = {8'd0, cfg.device_desc_len};
					end
					usbreq_pkg::DT_CONFIG: begin
						src  = usbreq_pkg::SRC_CONFIG;
						dlen = cfg.config_total_len;
					end
					usbreq_pkg::DT_STRING: begin
						if (vlo >= 8'(usbreq_pkg::NUM_STRINGS)) begin
							stall = 1'b1;
						end else begin
							src  = usbreq_pkg::SRC_STRING;
							strn = vlo[1:0];
							dlen = {8'd0, str_sh[7:0]};
						end
					end
					usbreq_pkg::DT_INTERFACE: begin
						src  = usbreq_pkg::SRC_INTERFACE;
						dlen = {8'd0, cfg.interface_desc_len};
					end
					usbreq_pkg::DT_ENDPOINT: begin
						if (vlo == usbreq_pkg::EP1_IN_ADDR) begin
							src  = usbreq_pkg::SRC_ENDPOINT;
							dlen = {8'd0, cfg.endpoint_desc_len};
						end else begin
							stall = 1'b1;
						end
					end
					usbreq_pkg::DT_HID: begin
						src   = usbreq_pkg::SRC_HID;
						dlen  = {8'd0, cfg.hid_desc_len};
						trunc = 1'b0;
					end
					usbreq_pkg::DT_REPORT: begin
						src   = usbreq_pkg::SRC_REPORT;
						dlen  = cfg.report_desc_len;
						trunc = 1'b0;
					end
					default: stall = 1'b1;
				endcase
				// clip to wLength only for short requests, not for HID or report descriptors
				if (trunc && len < 16'd256 && len < dlen)
					dlen = len;
			end
			usbreq_pkg::CMD_GET_CONFIG: begin
				if (rt != usbreq_pkg::RT_D2H_DEVICE || val != usbreq_pkg::WORD_ZERO
						|| idx != usbreq_pkg::WORD_ZERO || len != 16'd1)
					stall = 1'b1;
				else
					ibyte = configured;
				phase = usbreq_pkg::PH_TX;
				dlen  = 16'd1;
			end
			usbreq_pkg::CMD_SET_CONFIG: begin
				if (cur.state == usbreq_pkg::ST_DEFAULT || rt != usbreq_pkg::RT_H2D_DEVICE
						|| idx != usbreq_pkg::WORD_ZERO || len != usbreq_pkg::WORD_ZERO
						|| val > 16'd1) begin
					stall = 1'b1;
				end else if (val == 16'd1) begin
					upd.state      = usbreq_pkg::ST_CONFIGURED;
					upd.ep1_halted = 1'b0;
				end else begin
					upd.state      = usbreq_pkg::ST_ADDRESSED;
					upd.ep1_halted = 1'b1;
				end
			end
			usbreq_pkg::CMD_GET_INTERFACE: begin
				if (!configured || rt != usbreq_pkg::RT_D2H_INTERFACE
						|| val != usbreq_pkg::WORD_ZERO || idx != usbreq_pkg::WORD_ZERO
						|| len != 16'd1)
					stall = 1'b1;
				phase = usbreq_pkg::PH_TX;
				dlen  = 16'd1;
			end
			usbreq_pkg::CMD_SET_INTERFACE: begin
				if (rt != usbreq_pkg::RT_H2D_INTERFACE || len != usbreq_pkg::WORD_ZERO
						|| val != usbreq_pkg::WORD_ZERO || idx != usbreq_pkg::WORD_ZERO)
					stall = 1'b1;
			end
			default: stall = 1'b1;
		endcase
	end

	// A stalled request reports nothing and keeps the state
	assign nxt = stall ? cur : upd;

	always_comb begin
		res.stall_res        = stall;
		res.phase            = stall ? usbreq_pkg::PH_STATUS : phase;
		res.reply_source     = stall ? usbreq_pkg::SRC_INLINE : src;
		res.string_number    = stall ? 2'd0 : strn;
		res.inline_byte      = stall ? 1'b0 : ibyte;
		res.data_len         = stall ? 16'd0 : dlen;
		res.address_pending  = stall ? 1'b0 : apend;
		res.new_address      = stall ? 7'd0 : naddr;
		res.device_state_out = nxt.state;
		res.ep1_halted_out   = nxt.ep1_halted;
	end

endmodule

`default_nettype wire

// ===== sv/usb_standard_request_handler.sv =====
// A request beat is registered, checked, and its result beat is then registered. Throughput:
// one request per cycle while m_axis_tready allows; the input and result registers are
// separated so a new request is taken while a result waits for m_axis_tready, provided
// the input register is empty. Device state updates as each request moves into the result
// register. Reset (arst_n low, asynchronous) clears both beat registers, sets the default
// device state with endpoint 0x81 not halted, and loads the descriptor length registers.
`default_nettype none
`include "usb_standard_request_handler_macros.svh"

module usb_standard_request_handler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [3:0] cmd, [11:4] request_type, [27:12] setup_value, [43:28] setup_index,
	// [59:44] setup_length, [63:60] zero
	input  wire logic [63:0] s_axis_tdata,
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] stall_res, [2:1] phase, [5:3] reply_source, [7:6] string_number,
	// [8] inline_byte, [24:9] data_len, [25] address_pending, [32:26] new_address,
	// [34:33] device_state_out, [35] ep1_halted_out, [39:36] zero
	output logic [39:0]      m_axis_tdata,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	usbreq_pkg::cfg_t   cfg_q;
	usbreq_pkg::dev_t   dev_q;
	usbreq_pkg::dev_t   dev_nxt;
	usbreq_pkg::req_t   req_s1;
	logic               valid_s1;
	usbreq_pkg::res_t   res_nxt;
	usbreq_pkg::res_t   res_q;
	logic               out_valid_q;
	logic               adv;
	logic               cfg_wr;
	usbreq_pkg::reg_idx_t reg_idx;

	assign reg_idx = usbreq_pkg::reg_idx_t'(paddr[4:2]);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_desc_len    <= 8'd18;
			cfg_q.config_total_len   <= 16'd34;
			cfg_q.interface_desc_len <= 8'd9;
			cfg_q.endpoint_desc_len  <= 8'd7;
			cfg_q.hid_desc_len       <= 8'd9;
			cfg_q.report_desc_len    <= 16'd0;
			cfg_q.string_lens        <= 24'd0;
		end else if (cfg_wr) begin
			case (reg_idx)
				usbreq_pkg::REG_DEVICE_DESC_LEN:    cfg_q.device_desc_len    <= pwdata[7:0];
				usbreq_pkg::REG_CONFIG_TOTAL_LEN:   cfg_q.config_total_len   <= pwdata[15:0];
				usbreq_pkg::REG_INTERFACE_DESC_LEN: cfg_q.interface_desc_len <= pwdata[7:0];
				usbreq_pkg::REG_ENDPOINT_DESC_LEN:  cfg_q.endpoint_desc_len  <= pwdata[7:0];
				usbreq_pkg::REG_HID_DESC_LEN:       cfg_q.hid_desc_len       <= pwdata[7:0];
				usbreq_pkg::REG_REPORT_DESC_LEN:    cfg_q.report_desc_len    <= pwdata[15:0];
				usbreq_pkg::REG_STRING_LENS:        cfg_q.string_lens        <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			usbreq_pkg::REG_DEVICE_DESC_LEN:    prdata = {24'd0, cfg_q.device_desc_len};
			usbreq_pkg::REG_CONFIG_TOTAL_LEN:   prdata = {16'd0, cfg_q.config_total_len};
			usbreq_pkg::REG_INTERFACE_DESC_LEN: prdata = {24'd0, cfg_q.interface_desc_len};
			usbreq_pkg::REG_ENDPOINT_DESC_LEN:  prdata = {24'd0, cfg_q.endpoint_desc_len};
			usbreq_pkg::REG_HID_DESC_LEN:       prdata = {24'd0, cfg_q.hid_desc_len};
			usbreq_pkg::REG_REPORT_DESC_LEN:    prdata = {16'd0, cfg_q.report_desc_len};
			usbreq_pkg::REG_STRING_LENS:        prdata = {8'd0, cfg_q.string_lens};
			default:                            prdata = 32'd0;
		endcase
	end

	// Stage 1 moves on when the result register is free or being drained
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (s_axis_tvalid && s_axis_tready) || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1 <= usbreq_pkg::req_t'(s_axis_tdata[59:0]);
		end
	end

	usbreq_decode u_decode (
		.req (req_s1),
		.cfg (cfg_q),
		.cur (dev_q),
		.res (res_nxt),
		.nxt (dev_nxt)
	);

	// Device state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q.state      <= usbreq_pkg::ST_DEFAULT;
			dev_q.ep1_halted <= 1'b0;
			out_valid_q      <= 1'b0;
		end else if (adv) begin
			dev_q       <= dev_nxt;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, res_q};

	// Checks
	`USBREQ_ASSERT_IMPLY(a_stall_empty, clk, arst_n, out_valid_q && res_q.stall_res, res_q.data_len == 16'd0 && !res_q.address_pending && res_q.phase == usbreq_pkg::PH_STATUS)
	`USBREQ_ASSERT_NEXT(a_state_hold, clk, arst_n, !adv, $stable(dev_q))
	`USBREQ_ASSERT_IMPLY(a_addr_state, clk, arst_n, out_valid_q && res_q.address_pending, res_q.device_state_out == usbreq_pkg::ST_ADDRESSED)
	`USBREQ_ASSERT_IMPLY(a_addr_nonzero, clk, arst_n, out_valid_q, res_q.address_pending == (res_q.new_address != 7'd0))

endmodule

`default_nettype wire

// ===== tb/sv/usb_standard_request_handler_test.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the USB standard request handler.

module usb_standard_request_handler_test;
	import usbreq_pkg::*;

	localparam int QUIET_LIMIT  = 2000;  // cycles without any accepted beat
	localparam int DRAIN_CYCLES = 4;     // pause after the last result
	localparam int CHUNK_ITEMS  = 200;
	localparam int NUM_CHUNKS   = 6;
	localparam int PRINT_CAP    = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire logic   s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	wire logic   m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire [39:0]  m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire [31:0]  prdata;
	wire logic   pready;

	// Pending request beats and predicted answers
	req_t pending_requests[$];
	res_t expected_results[$];

	// Predictor copy of the device state and the length registers
	dev_t dev_model;
	cfg_t desc_lens;

	int unsigned send_idle_pct = 13;
	int unsigned recv_idle_pct = 67;
	int          mismatch_count = 0;
	int          result_count = 0;
	int          quiet_cycles = 0;
	logic        req_beat_taken = 1'b0;
	res_t        got_res;
	res_t        want_res;

	usb_standard_request_handler uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		// keep the log bounded when everything goes wrong
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch: %s", what);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
				result_count, name, got, want));
	endtask

	// Chapter-9 decision for one request; updates the model state unless it stalls
	function automatic res_t predict_outcome(input req_t rq);
		res_t       r;
		dev_t       nxt;
		logic       bad;
		logic       configured;
		logic       trunc;
		logic [7:0] vlo;
		logic [7:0] vhi;
		logic [7:0] ilo;
		logic [7:0] ihi;
		logic [15:0] dlen;
		r = '0;
		nxt = dev_model;
		bad = 1'b0;
		trunc = 1'b1;
		dlen = WORD_ZERO;
		vlo = rq.setup_value[7:0];
		vhi = rq.setup_value[15:8];
		ilo = rq.setup_index[7:0];
		ihi = rq.setup_index[15:8];
		configured = (dev_model.state == ST_CONFIGURED);
		case (rq.cmd)
			CMD_GET_STATUS: begin
				if (rq.setup_value != WORD_ZERO || rq.setup_length != 16'd2)
					bad = 1'b1;
				else if (rq.request_type == RT_D2H_DEVICE)
					bad = (rq.setup_index != WORD_ZERO);
				else if (rq.request_type == RT_D2H_INTERFACE)
					bad = !configured || rq.setup_index != WORD_ZERO;
				else if (rq.request_type == RT_D2H_ENDPOINT) begin
					if (!configured || ihi != 8'h00 || ilo != EP1_IN_ADDR)
						bad = 1'b1;
					else
						r.inline_byte = dev_model.ep1_halted;
				end else
					bad = 1'b1;
				r.phase = PH_TX;
				dlen = 16'd2;
			end
			CMD_CLEAR_FEATURE, CMD_SET_FEATURE: begin
				if (!configured || rq.setup_value != WORD_ZERO ||
						rq.setup_length != WORD_ZERO ||
						rq.request_type != RT_H2D_ENDPOINT || vlo != FEAT_EP_HALT ||
						ilo != EP1_IN_ADDR)
					bad = 1'b1;
				else
					nxt.ep1_halted = (rq.cmd == CMD_SET_FEATURE);
			end
			CMD_SET_ADDRESS: begin
				if (rq.request_type != RT_H2D_DEVICE || rq.setup_index != WORD_ZERO ||
						rq.setup_length != WORD_ZERO || rq.setup_value == WORD_ZERO ||
						rq.setup_value > MAX_ADDRESS)
					bad = 1'b1;
				else begin
					r.address_pending = 1'b1;
					r.new_address = rq.setup_value[6:0];
					nxt.state = ST_ADDRESSED;
				end
			end
			CMD_GET_DESCRIPTOR: begin
				r.phase = PH_TX;
				case (vhi)
					DT_DEVICE: begin
						r.reply_source = SRC_DEVICE;
						dlen = {8'h00, desc_lens.device_desc_len};
					end
					DT_CONFIG: begin
						r.reply_source = SRC_CONFIG;
						dlen = desc_lens.config_total_len;
					end
					DT_STRING: begin
						if (vlo >= NUM_STRINGS)
							bad = 1'b1;
						else begin
							r.reply_source = SRC_STRING;
							r.string_number = vlo[1:0];
							case (vlo[1:0])
								2'd0: dlen = {8'h00, desc_lens.string_lens[7:0]};
								2'd1: dlen = {8'h00, desc_lens.string_lens[15:8]};
								default: dlen = {8'h00, desc_lens.string_lens[23:16]};
							endcase
						end
					end
					DT_INTERFACE: begin
						r.reply_source = SRC_INTERFACE;
						dlen = {8'h00, desc_lens.interface_desc_len};
					end
					DT_ENDPOINT: begin
						if (vlo == EP1_IN_ADDR) begin
							r.reply_source = SRC_ENDPOINT;
							dlen = {8'h00, desc_lens.endpoint_desc_len};
						end else
							bad = 1'b1;
					end
					DT_HID: begin
						r.reply_source = SRC_HID;
						dlen = {8'h00, desc_lens.hid_desc_len};
						trunc = 1'b0;
					end
					DT_REPORT: begin
						r.reply_source = SRC_REPORT;
						dlen = desc_lens.report_desc_len;
						trunc = 1'b0;
					end
					default: bad = 1'b1;
				endcase
				// short wLength cuts the reply, but only below 256 and not for HID/report
				if (trunc && rq.setup_length < 16'd256 && rq.setup_length < dlen)
					dlen = rq.setup_length;
			end
			CMD_GET_CONFIG: begin
				if (rq.request_type != RT_D2H_DEVICE || rq.setup_value != WORD_ZERO ||
						rq.setup_index != WORD_ZERO || rq.setup_length != 16'd1)
					bad = 1'b1;
				else
					r.inline_byte = configured;
				r.phase = PH_TX;
				dlen = 16'd1;
			end
			CMD_SET_CONFIG: begin
				if (dev_model.state == ST_DEFAULT || rq.request_type != RT_H2D_DEVICE ||
						rq.setup_index != WORD_ZERO || rq.setup_length != WORD_ZERO ||
						rq.setup_value > 16'd1)
					bad = 1'b1;
				else if (rq.setup_value == 16'd1) begin
					nxt.state = ST_CONFIGURED;
					nxt.ep1_halted = 1'b0;
				end else begin
					// deconfigure leaves the endpoint halted
					nxt.state = ST_ADDRESSED;
					nxt.ep1_halted = 1'b1;
				end
			end
			CMD_GET_INTERFACE: begin
				if (!configured || rq.request_type != RT_D2H_INTERFACE ||
						rq.setup_value != WORD_ZERO || rq.setup_index != WORD_ZERO ||
						rq.setup_length != 16'd1)
					bad = 1'b1;
				r.phase = PH_TX;
				dlen = 16'd1;
			end
			CMD_SET_INTERFACE: begin
				if (rq.request_type != RT_H2D_INTERFACE || rq.setup_length != WORD_ZERO ||
						rq.setup_value != WORD_ZERO || rq.setup_index != WORD_ZERO)
					bad = 1'b1;
			end
			default: bad = 1'b1;
		endcase
		// a stall blanks the answer and keeps the state
		if (bad) begin
			r = '0;
			r.stall_res = 1'b1;
		end else begin
			dev_model = nxt;
			r.data_len = dlen;
		end
		r.device_state_out = dev_model.state;
		r.ep1_halted_out = dev_model.ep1_halted;
		return r;
	endfunction

	function automatic req_t make_setup(input cmd_t c, input logic [7:0] rt,
			input logic [15:0] v, input logic [15:0] i, input logic [15:0] l);
		req_t rq;
		rq.cmd = c;
		rq.request_type = rt;
		rq.setup_value = v;
		rq.setup_index = i;
		rq.setup_length = l;
		return rq;
	endfunction

	// Mostly well-formed requests, some with one broken field, some pure noise
	function automatic req_t make_random_request();
		req_t        rq;
		int unsigned shape;
		logic [7:0]  dtype;
		logic [7:0]  dindex;
		shape = $urandom_range(0, 99);
		rq = '0;
		rq.cmd = 4'($urandom_range(CMD_GET_STATUS, CMD_SET_INTERFACE));
		case (rq.cmd)
			CMD_GET_STATUS: begin
				case ($urandom_range(0, 2))
					0: rq.request_type = RT_D2H_DEVICE;
					1: rq.request_type = RT_D2H_INTERFACE;
					default: begin
						rq.request_type = RT_D2H_ENDPOINT;
						rq.setup_index = {8'h00, EP1_IN_ADDR};
					end
				endcase
				rq.setup_length = 16'd2;
			end
			CMD_CLEAR_FEATURE, CMD_SET_FEATURE: begin
				rq.request_type = RT_H2D_ENDPOINT;
				rq.setup_value = {8'h00, FEAT_EP_HALT};
				rq.setup_index = {8'($urandom_range(0, 1)), EP1_IN_ADDR};
			end
			CMD_SET_ADDRESS: begin
				rq.request_type = RT_H2D_DEVICE;
				rq.setup_value = 16'($urandom_range(1, MAX_ADDRESS));
			end
			CMD_GET_DESCRIPTOR: begin
				case ($urandom_range(0, 7))
					0: dtype = DT_DEVICE;
					1: dtype = DT_CONFIG;
					2: dtype = DT_STRING;
					3: dtype = DT_INTERFACE;
					4: dtype = DT_ENDPOINT;
					5: dtype = DT_HID;
					6: dtype = DT_REPORT;
					default: dtype = 8'($urandom);
				endcase
				dindex = 8'($urandom_range(0, 3));
				if (dtype == DT_ENDPOINT && $urandom_range(0, 3) != 0)
					dindex = EP1_IN_ADDR;
				rq.request_type = RT_D2H_DEVICE;
				rq.setup_value = {dtype, dindex};
				rq.setup_index = $urandom_range(0, 1) ? 16'h0409 : WORD_ZERO;
				// lengths around the 256 truncation edge and the full range
				case ($urandom_range(0, 5))
					0: rq.setup_length = 16'($urandom_range(0, 255));
					1: rq.setup_length = 16'd255;
					2: rq.setup_length = 16'd256;
					3: rq.setup_length = 16'hffff;
					4: rq.setup_length = 16'($urandom);
					default: rq.setup_length = 16'($urandom_range(0, 40));
				endcase
			end
			CMD_GET_CONFIG: begin
				rq.request_type = RT_D2H_DEVICE;
				rq.setup_length = 16'd1;
			end
			CMD_SET_CONFIG: begin
				rq.request_type = RT_H2D_DEVICE;
				rq.setup_value = 16'($urandom_range(0, 1));
			end
			CMD_GET_INTERFACE: begin
				rq.request_type = RT_D2H_INTERFACE;
				rq.setup_length = 16'd1;
			end
			default: rq.request_type = RT_H2D_INTERFACE;
		endcase
		if (shape >= 85) begin
			rq.cmd = 4'($urandom);
			rq.request_type = 8'($urandom);
			rq.setup_value = 16'($urandom);
			rq.setup_index = 16'($urandom);
			rq.setup_length = 16'($urandom);
		end else if (shape >= 65) begin
			case ($urandom_range(0, 4))
				0: rq.cmd = 4'($urandom);
				1: rq.request_type = 8'($urandom);
				2: rq.setup_value = 16'($urandom);
				3: rq.setup_index = 16'($urandom);
				default: rq.setup_length = 16'($urandom);
			endcase
		end
		return rq;
	endfunction

	// APB write: setup cycle, then access cycle
	task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DEVICE_DESC_LEN:    desc_lens.device_desc_len = value[7:0];
			REG_CONFIG_TOTAL_LEN:   desc_lens.config_total_len = value[15:0];
			REG_INTERFACE_DESC_LEN: desc_lens.interface_desc_len = value[7:0];
			REG_ENDPOINT_DESC_LEN:  desc_lens.endpoint_desc_len = value[7:0];
			REG_HID_DESC_LEN:       desc_lens.hid_desc_len = value[7:0];
			REG_REPORT_DESC_LEN:    desc_lens.report_desc_len = value[15:0];
			default:                desc_lens.string_lens = value[23:0];
		endcase
	endtask

	task automatic apply_lengths(input logic [7:0] dd, input logic [15:0] ct,
			input logic [7:0] id, input logic [7:0] ed, input logic [7:0] hd,
			input logic [15:0] rd, input logic [23:0] sl);
		write_register(REG_DEVICE_DESC_LEN, {24'h0, dd});
		write_register(REG_CONFIG_TOTAL_LEN, {16'h0, ct});
		write_register(REG_INTERFACE_DESC_LEN, {24'h0, id});
		write_register(REG_ENDPOINT_DESC_LEN, {24'h0, ed});
		write_register(REG_HID_DESC_LEN, {24'h0, hd});
		write_register(REG_REPORT_DESC_LEN, {16'h0, rd});
		write_register(REG_STRING_LENS, {8'h0, sl});
	endtask

	// Sender holds off until every outstanding answer is back, then a short pause
	task automatic wait_until_drained();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || s_axis_tvalid ||
			expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || req_beat_taken) begin
				if (pending_requests.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'h0, pending_requests.pop_front()};
				end else
					s_axis_tvalid <= 1'b0;
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: predict on each request beat, check each result beat
	always @(posedge clk) begin
		if (arst_n) begin
			req_beat_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				result_count++;
				if (expected_results.size() == 0)
					report_mismatch($sformatf("result %0d: beat with nothing expected",
						result_count));
				else begin
					got_res = m_axis_tdata[35:0];
					want_res = expected_results.pop_front();
					check_field("stall_res", 16'(got_res.stall_res), 16'(want_res.stall_res));
					check_field("phase", 16'(got_res.phase), 16'(want_res.phase));
					check_field("reply_source", 16'(got_res.reply_source),
						16'(want_res.reply_source));
					check_field("string_number", 16'(got_res.string_number),
						16'(want_res.string_number));
					check_field("inline_byte", 16'(got_res.inline_byte),
						16'(want_res.inline_byte));
					check_field("data_len", got_res.data_len, want_res.data_len);
					check_field("address_pending", 16'(got_res.address_pending),
						16'(want_res.address_pending));
					check_field("new_address", 16'(got_res.new_address),
						16'(want_res.new_address));
					check_field("device_state_out", 16'(got_res.device_state_out),
						16'(want_res.device_state_out));
					check_field("ep1_halted_out", 16'(got_res.ep1_halted_out),
						16'(want_res.ep1_halted_out));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(predict_outcome(s_axis_tdata[59:0]));
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Watchdog
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// Main sequence
	initial begin
		int chunk;
		dev_model = '{state: ST_DEFAULT, ep1_halted: 1'b0};
		desc_lens = '{device_desc_len: 8'd18, config_total_len: 16'd34,
			interface_desc_len: 8'd9, endpoint_desc_len: 8'd7, hid_desc_len: 8'd9,
			report_desc_len: 16'd0, string_lens: 24'd0};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset lengths, default state first, then addressed and configured
		pending_requests.push_back(make_setup(CMD_GET_STATUS, RT_D2H_DEVICE, 0, 0, 2));
		pending_requests.push_back(make_setup(CMD_GET_STATUS, RT_D2H_INTERFACE, 0, 0, 2));
		pending_requests.push_back(make_setup(CMD_GET_CONFIG, RT_D2H_DEVICE, 0, 0, 1));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			{DT_DEVICE, 8'h00}, 0, 16'h0040));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			{DT_DEVICE, 8'h00}, 0, 16'd8));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			{DT_CONFIG, 8'h00}, 0, 16'hffff));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			{DT_STRING, 8'h00}, 16'h0409, 16'h00ff));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			{DT_STRING, 8'h03}, 16'h0409, 16'h00ff));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			{DT_ENDPOINT, EP1_IN_ADDR}, 0, 16'h00ff));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			{DT_ENDPOINT, 8'h01}, 0, 16'h00ff));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			{DT_HID, 8'h00}, 0, 16'd1));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			{DT_REPORT, 8'h00}, 0, 16'h0100));
		pending_requests.push_back(make_setup(CMD_GET_DESCRIPTOR, RT_D2H_DEVICE,
			16'h0600, 0, 16'h0040));
		pending_requests.push_back(make_setup(CMD_SET_FEATURE, RT_H2D_ENDPOINT,
			0, {8'h00, EP1_IN_ADDR}, 0));
		pending_requests.push_back(make_setup(CMD_SET_CONFIG, RT_H2D_DEVICE, 1, 0, 0));
		pending_requests.push_back(make_setup(CMD_SET_ADDRESS, RT_H2D_DEVICE, 0, 0, 0));
		pending_requests.push_back(make_setup(CMD_SET_ADDRESS, RT_H2D_DEVICE,
			MAX_ADDRESS, 0, 0));
		pending_requests.push_back(make_setup(CMD_GET_INTERFACE, RT_D2H_INTERFACE, 0, 0, 1));
		pending_requests.push_back(make_setup(CMD_SET_CONFIG, RT_H2D_DEVICE, 1, 0, 0));
		pending_requests.push_back(make_setup(CMD_GET_STATUS, RT_D2H_ENDPOINT,
			0, {8'h00, EP1_IN_ADDR}, 2));
		pending_requests.push_back(make_setup(CMD_SET_FEATURE, RT_H2D_ENDPOINT,
			0, {8'h00, EP1_IN_ADDR}, 0));
		pending_requests.push_back(make_setup(CMD_GET_STATUS, RT_D2H_ENDPOINT,
			0, {8'h00, EP1_IN_ADDR}, 2));
		pending_requests.push_back(make_setup(CMD_CLEAR_FEATURE, RT_H2D_ENDPOINT,
			0, {8'h00, EP1_IN_ADDR}, 0));
		pending_requests.push_back(make_setup(CMD_GET_CONFIG, RT_D2H_DEVICE, 0, 0, 1));
		pending_requests.push_back(make_setup(CMD_GET_INTERFACE, RT_D2H_INTERFACE, 0, 0, 1));
		pending_requests.push_back(make_setup(CMD_SET_INTERFACE, RT_H2D_INTERFACE, 0, 0, 0));
		pending_requests.push_back(make_setup(CMD_SET_CONFIG, RT_H2D_DEVICE, 0, 0, 0));
		pending_requests.push_back(make_setup(CMD_SET_IDLE, 8'h21, 0, 0, 0));
		pending_requests.push_back(make_setup(CMD_OTHER, RT_D2H_DEVICE, 0, 0, 0));
		pending_requests.push_back(make_setup(CMD_GET_STATUS, 8'h83, 0, 0, 2));
		wait_until_drained();

		// Random chunks, each under its own length settings; idle pattern per chunk pair
		for (chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
			case (chunk)
				0: apply_lengths(8'hff, 16'hffff, 8'hff, 8'hff, 8'hff, 16'hffff, 24'hffffff);
				1: apply_lengths(8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 24'h000000);
				3: apply_lengths(8'($urandom_range(0, 24)), 16'($urandom_range(0, 24)),
					8'($urandom_range(0, 24)), 8'($urandom_range(0, 24)),
					8'($urandom_range(0, 24)), 16'($urandom_range(0, 24)),
					24'($urandom));
				default: apply_lengths(8'($urandom), 16'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 16'($urandom), 24'($urandom));
			endcase
			if (chunk < 2) begin
				send_idle_pct = 13;
				recv_idle_pct = 67;
			end else if (chunk < 4) begin
				send_idle_pct = 67;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (CHUNK_ITEMS) pending_requests.push_back(make_random_request());
			wait_until_drained();
		end

		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/usbreq_pkg.sv
sv/usbreq_decode.sv
sv/usb_standard_request_handler.sv
tb/sv/usb_standard_request_handler_test.sv
